### rtl/core/rphc_pkg.sv
// Shared types, constants and a helper function for the hollow cylinder point generator.
package rphc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int RAND_WIDTH = 32;
    localparam int CFG_WIDTH = 48;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 60;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_X = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_Y = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_Z = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INNER = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTER = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEIGHT = 3'd6;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    localparam logic signed [32:0] CORDIC_ATAN [0:CORDIC_STEPS-1] = '{
        33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4, 33'sh028B0D43,
        33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55, 33'sh0028BE53, 33'sh00145F2F,
        33'sh000A2F98, 33'sh000517CC, 33'sh00028BE6, 33'sh000145F3, 33'sh0000A2F9,
        33'sh0000517C, 33'sh000028BE, 33'sh0000145F, 33'sh00000A2F, 33'sh00000517,
        33'sh0000028B, 33'sh00000145, 33'sh000000A2, 33'sh00000051, 33'sh00000028,
        33'sh00000014, 33'sh0000000A, 33'sh00000005, 33'sh00000002, 33'sh00000001
    };

    typedef struct packed {
        logic [RAND_WIDTH-1:0] rand_angle;
        logic [RAND_WIDTH-1:0] rand_radius;
        logic [RAND_WIDTH-1:0] rand_height;
    } sample_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          clipped;
    } point_t;

    typedef struct packed {
        logic [2:0][15:0]            axis;
        logic [2:0][31:0]            bvec;
        logic [2:0][34:0]            cvec;
        logic [2:0][COORD_WIDTH-1:0] base;
        logic [63:0]                 rsq_base;
        logic [63:0]                 rsq_span;
        logic                        rsq_down;
        logic [31:0]                 height;
    } geom_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } sqrt_t;

    function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [63:0] bitv);
        sqrt_t       o;
        logic [63:0] t;
        begin
            t = s.res + bitv;
            if (s.v >= t)
            begin
                o.v = s.v - t;
                o.res = (s.res >> 1) + bitv;
            end
            else
            begin
                o.v = s.v;
                o.res = s.res >> 1;
            end
            return o;
        end
    endfunction

endpackage

### rtl/core/random_point_in_hollow_cylinder.sv
// Top level: configuration registers, basis sequencer and the point datapath.
//
// Channel   Direction  Signals                           Transfer
// config    in         cfg_write, cfg_index, cfg_data    edge with cfg_write high
// sample    in         start, busy, sample               edge with start high, busy low
// point     out        done, point                       the one cycle done is high
//
// One sample is taken per cycle while busy is low.
// The 30-stage CORDIC feeds the rotation multipliers and the
// 32-stage radius square root feeds the radius multipliers.
// After reset and after every register write, busy stays high while
// one shared square root and two bit-serial dividers derive the perpendicular basis.
// When an axis component is zero the basis is a unit vector and the square root and dividers are skipped.
// Results cannot be stalled; the pipeline always advances.
module random_point_in_hollow_cylinder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  rphc_pkg::sample_t                      sample,
    input  logic                                   cfg_write,
    input  logic [rphc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [rphc_pkg::CFG_WIDTH-1:0]         cfg_data,
    output logic                                   done,
    output rphc_pkg::point_t                       point
);

    localparam int CW = rphc_pkg::COORD_WIDTH;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef enum logic [2:0] {
        S_PREP,
        S_DIFF,
        S_SQRT,
        S_DIV,
        S_CROSS,
        S_IDLE
    } seq_state_t;

    seq_state_t          state_reg;
    logic [5:0]          cnt_reg;
    logic [47:0]         axis_reg;
    logic [CW-1:0]       base_reg [0:2];
    logic [31:0]         inner_reg, outer_reg, height_reg;
    logic [63:0]         c1_reg, c2_reg, span_reg;
    logic                down_reg;
    rphc_pkg::sqrt_t     sq_reg;
    rphc_pkg::sqrt_t     sq_next;
    logic [63:0]         sqb_reg;
    logic [31:0]         len_reg;
    logic [59:0]         numy_reg, numx_reg;
    logic [31:0]         remy_reg, remx_reg, qy_reg, qx_reg;
    logic [31:0]         remy_sh, remx_sh, remy_next, remx_next, qy_next, qx_next;
    logic                gey, gex;
    logic signed [31:0]  b_reg [0:2];
    logic signed [34:0]  cr_reg [0:2];
    logic signed [15:0]  a14 [0:2];
    logic [15:0]         mx, my;
    logic [31:0]         ssum;
    logic signed [15:0]  m1, m2;
    logic signed [31:0]  n1, n2;
    logic signed [48:0]  cdiff;
    rphc_pkg::geom_t     geom;
    logic                pipe_valid;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a14[k] = $signed(axis_reg[16*k +: 16]);
        end
        mx = a14[0][15] ? 16'(-a14[0]) : 16'(a14[0]);
        my = a14[1][15] ? 16'(-a14[1]) : 16'(a14[1]);
        ssum = 32'(32'(a14[0]) * 32'(a14[0])) + 32'(32'(a14[1]) * 32'(a14[1]));
        sq_next = rphc_pkg::sqrt_step(sq_reg, sqb_reg);
        remy_sh = {remy_reg[30:0], numy_reg[59]};
        remx_sh = {remx_reg[30:0], numx_reg[59]};
        gey = remy_sh >= len_reg;
        gex = remx_sh >= len_reg;
        remy_next = gey ? remy_sh - len_reg : remy_sh;
        remx_next = gex ? remx_sh - len_reg : remx_sh;
        qy_next = {qy_reg[30:0], gey};
        qx_next = {qx_reg[30:0], gex};
        case (cnt_reg[1:0])
            2'd0:
            begin
                m1 = a14[1]; n1 = b_reg[2]; m2 = a14[2]; n2 = b_reg[1];
            end
            2'd1:
            begin
                m1 = a14[2]; n1 = b_reg[0]; m2 = a14[0]; n2 = b_reg[2];
            end
            default:
            begin
                m1 = a14[0]; n1 = b_reg[1]; m2 = a14[1]; n2 = b_reg[0];
            end
        endcase
        cdiff = 49'(m1) * 49'(n1) - 49'(m2) * 49'(n2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= 48'h4000_0000_0000;
            base_reg[0] <= '0;
            base_reg[1] <= '0;
            base_reg[2] <= '0;
            inner_reg <= '0;
            outer_reg <= 32'h0100_0000;
            height_reg <= 32'h0100_0000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rphc_pkg::REG_AXIS:   axis_reg <= cfg_data[47:0];
                rphc_pkg::REG_BASE_X: base_reg[0] <= cfg_data[CW-1:0];
                rphc_pkg::REG_BASE_Y: base_reg[1] <= cfg_data[CW-1:0];
                rphc_pkg::REG_BASE_Z: base_reg[2] <= cfg_data[CW-1:0];
                rphc_pkg::REG_INNER:  inner_reg <= cfg_data[31:0];
                rphc_pkg::REG_OUTER:  outer_reg <= cfg_data[31:0];
                rphc_pkg::REG_HEIGHT: height_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_PREP;
            cnt_reg <= '0;
        end
        else if (cfg_write)
        begin
            state_reg <= S_PREP;
            cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_PREP:
                begin
                    c1_reg <= 64'(inner_reg) * 64'(inner_reg);
                    c2_reg <= 64'(outer_reg) * 64'(outer_reg);
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    down_reg <= c2_reg < c1_reg;
                    span_reg <= (c2_reg < c1_reg) ? c1_reg - c2_reg : c2_reg - c1_reg;
                    cnt_reg <= '0;
                    if (a14[0] == 16'sd0)
                    begin
                        b_reg[0] <= ONE_Q30; b_reg[1] <= '0; b_reg[2] <= '0;
                        state_reg <= S_CROSS;
                    end
                    else if (a14[1] == 16'sd0)
                    begin
                        b_reg[0] <= '0; b_reg[1] <= ONE_Q30; b_reg[2] <= '0;
                        state_reg <= S_CROSS;
                    end
                    else if (a14[2] == 16'sd0)
                    begin
                        b_reg[0] <= '0; b_reg[1] <= '0; b_reg[2] <= ONE_Q30;
                        state_reg <= S_CROSS;
                    end
                    else
                    begin
                        sq_reg.v <= 64'(ssum) << 28;
                        sq_reg.res <= '0;
                        sqb_reg <= 64'(1) << 62;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    sq_reg <= sq_next;
                    sqb_reg <= sqb_reg >> 2;
                    if (cnt_reg == 6'(rphc_pkg::SQRT_STEPS - 1))
                    begin
                        len_reg <= sq_next.res[31:0];
                        numy_reg <= {my, 44'd0};
                        numx_reg <= {mx, 44'd0};
                        remy_reg <= '0;
                        remx_reg <= '0;
                        qy_reg <= '0;
                        qx_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_DIV:
                begin
                    numy_reg <= numy_reg << 1;
                    numx_reg <= numx_reg << 1;
                    remy_reg <= remy_next;
                    remx_reg <= remx_next;
                    qy_reg <= qy_next;
                    qx_reg <= qx_next;
                    if (cnt_reg == 6'(rphc_pkg::DIV_STEPS - 1))
                    begin
                        b_reg[0] <= a14[1][15] ? $signed(qy_next) : -$signed(qy_next);
                        b_reg[1] <= a14[0][15] ? -$signed(qx_next) : $signed(qx_next);
                        b_reg[2] <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_CROSS;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_CROSS:
                begin
                    cr_reg[cnt_reg[1:0]] <= 35'(cdiff >>> 14);
                    if (cnt_reg == 6'd2)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_IDLE: ;
                default:
                begin
                    state_reg <= S_PREP;
                end
            endcase
        end
    end

    always_comb
    begin
        geom.axis = axis_reg;
        for (int k = 0; k < 3; k++)
        begin
            geom.bvec[k] = b_reg[k];
            geom.cvec[k] = cr_reg[k];
            geom.base[k] = base_reg[k];
        end
        geom.rsq_base = c1_reg;
        geom.rsq_span = span_reg;
        geom.rsq_down = down_reg;
        geom.height = height_reg;
    end

    assign busy = state_reg != S_IDLE;

    rphc_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .sample    (sample),
        .geom      (geom),
        .out_valid (pipe_valid),
        .point     (point)
    );

    assign done = pipe_valid;

endmodule

### rtl/core/rphc_pipe.sv
// Point datapath: CORDIC, radius square root, basis rotation, scaling and saturation.
module rphc_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rphc_pkg::sample_t sample,
    input  rphc_pkg::geom_t  geom,
    output logic             out_valid,
    output rphc_pkg::point_t point
);

    localparam int CW = rphc_pkg::COORD_WIDTH;
    localparam int NC = rphc_pkg::CORDIC_STEPS;
    localparam int SQ_FIRST = 3;
    localparam int SQ_LAST = SQ_FIRST + rphc_pkg::SQRT_STEPS;
    localparam int LAST = SQ_LAST + 3;
    localparam int SUM_W = ((CW > 39) ? CW : 39) + 2;
    localparam logic signed [SUM_W-1:0] PMAX =
        {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] PMIN = ~PMAX;
    localparam logic [1:0] QUAD_FIRST = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD = 2'd2;

    logic [LAST:0]       vld_reg;
    logic [31:0]         u_ang, u_rad, u_hgt;
    logic [31:0]         u_rad_reg, u_hgt_reg;
    logic signed [33:0]  cx_reg [0:NC];
    logic signed [33:0]  cy_reg [0:NC];
    logic signed [32:0]  cz_reg [0:NC];
    logic [1:0]          q_reg [0:NC];
    logic signed [33:0]  co_reg, si_reg;
    logic [63:0]         mhi_reg, mlo_reg, mf_reg;
    rphc_pkg::sqrt_t     sq_reg [SQ_FIRST:SQ_LAST];
    logic [31:0]         hz_reg [1:SQ_LAST];
    logic signed [65:0]  pb_reg [0:2];
    logic signed [68:0]  pc_reg [0:2];
    logic signed [35:0]  dir0_reg [0:2];
    logic signed [35:0]  dir1_reg [0:2];
    logic signed [35:0]  dir2_reg [0:2];
    logic [35:0]         dmag [0:2];
    logic [15:0]         amag [0:2];
    logic [51:0]         phi_reg [0:2];
    logic [51:0]         plo_reg [0:2];
    logic [47:0]         hm_reg [0:2];
    logic [2:0]          dneg_reg, aneg_reg;
    logic signed [38:0]  t1_reg [0:2];
    logic signed [34:0]  t2_reg [0:2];
    logic signed [SUM_W-1:0] psum [0:2];
    logic signed [CW-1:0] pout [0:2];
    logic [2:0]          pclip;
    logic [31:0]         rad;
    rphc_pkg::point_t    point_reg;

    always_comb
    begin
        u_ang = 32'(sample.rand_angle) << (32 - rphc_pkg::RAND_WIDTH);
        u_rad = 32'(sample.rand_radius) << (32 - rphc_pkg::RAND_WIDTH);
        u_hgt = 32'(sample.rand_height) << (32 - rphc_pkg::RAND_WIDTH);
        rad = sq_reg[SQ_LAST].res[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0] <= rphc_pkg::CORDIC_START;
        cy_reg[0] <= '0;
        cz_reg[0] <= 33'(u_ang[29:0]);
        q_reg[0] <= u_ang[31:30];
        u_rad_reg <= u_rad;
        u_hgt_reg <= u_hgt;
    end

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (!cz_reg[i][32])
            begin
                cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] - rphc_pkg::CORDIC_ATAN[i];
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] + rphc_pkg::CORDIC_ATAN[i];
            end
            q_reg[i+1] <= q_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        case (q_reg[NC])
            QUAD_FIRST:
            begin
                co_reg <= cx_reg[NC];
                si_reg <= cy_reg[NC];
            end
            QUAD_SECOND:
            begin
                co_reg <= -cy_reg[NC];
                si_reg <= cx_reg[NC];
            end
            QUAD_THIRD:
            begin
                co_reg <= -cx_reg[NC];
                si_reg <= -cy_reg[NC];
            end
            default:
            begin
                co_reg <= cy_reg[NC];
                si_reg <= -cx_reg[NC];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mhi_reg <= 64'(geom.rsq_span[63:32]) * 64'(u_rad_reg);
        mlo_reg <= 64'(geom.rsq_span[31:0]) * 64'(u_rad_reg);
        mf_reg <= mhi_reg + (mlo_reg >> 32);
        sq_reg[SQ_FIRST].v <= geom.rsq_down ? geom.rsq_base - mf_reg
                                            : geom.rsq_base + mf_reg;
        sq_reg[SQ_FIRST].res <= '0;
        hz_reg[1] <= 32'((64'(geom.height) * 64'(u_hgt_reg)) >> 32);
        for (int j = 2; j <= SQ_LAST; j++)
        begin
            hz_reg[j] <= hz_reg[j-1];
        end
    end

    for (genvar j = 0; j < rphc_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            sq_reg[SQ_FIRST+j+1] <= rphc_pkg::sqrt_step(sq_reg[SQ_FIRST+j],
                                                         64'(1) << (62 - 2 * j));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dmag[k] = dir2_reg[k][35] ? 36'(-dir2_reg[k]) : 36'(dir2_reg[k]);
            amag[k] = geom.axis[k][15] ? 16'(-$signed(geom.axis[k])) : geom.axis[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pb_reg[k] <= 66'($signed(geom.bvec[k])) * 66'(co_reg);
            pc_reg[k] <= 69'($signed(geom.cvec[k])) * 69'(si_reg);
            dir0_reg[k] <= 36'((pb_reg[k] >>> 30) + (pc_reg[k] >>> 30));
            dir1_reg[k] <= dir0_reg[k];
            dir2_reg[k] <= dir1_reg[k];
            phi_reg[k] <= 52'(dmag[k]) * 52'(rad[31:16]);
            plo_reg[k] <= 52'(dmag[k]) * 52'(rad[15:0]);
            dneg_reg[k] <= dir2_reg[k][35];
            hm_reg[k] <= 48'(amag[k]) * 48'(hz_reg[SQ_LAST]);
            aneg_reg[k] <= geom.axis[k][15];
            t1_reg[k] <= dneg_reg[k]
                ? -39'(((68'(phi_reg[k]) << 16) + 68'(plo_reg[k])) >> 30)
                : 39'(((68'(phi_reg[k]) << 16) + 68'(plo_reg[k])) >> 30);
            t2_reg[k] <= aneg_reg[k] ? -35'(hm_reg[k] >> 14) : 35'(hm_reg[k] >> 14);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            psum[k] = SUM_W'($signed(geom.base[k])) + SUM_W'(t1_reg[k])
                      + SUM_W'(t2_reg[k]);
            if (psum[k] > PMAX)
            begin
                pout[k] = CW'(PMAX);
                pclip[k] = 1'b1;
            end
            else if (psum[k] < PMIN)
            begin
                pout[k] = CW'(PMIN);
                pclip[k] = 1'b1;
            end
            else
            begin
                pout[k] = CW'(psum[k]);
                pclip[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg.point_x <= pout[0];
        point_reg.point_y <= pout[1];
        point_reg.point_z <= pout[2];
        point_reg.clipped <= |pclip;
    end

    assign out_valid = vld_reg[LAST];
    assign point = point_reg;

endmodule
